/* hdl/gregorian_day_number_converter_defines.svh */
// Assertion macros for the day number converter
`ifndef GREGORIAN_DAY_NUMBER_CONVERTER_DEFINES_SVH
`define GREGORIAN_DAY_NUMBER_CONVERTER_DEFINES_SVH

// antecedent implies consequent, checked out of reset
`define GDNC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// plain invariant, checked out of reset
`define GDNC_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error(msg);

`endif

/* hdl/gdnc_pkg.sv */
// Shared constants and calendar tables for the day number converter
package gdnc_pkg;

  localparam int D2J_LAT = 4;
  localparam int J2D_LAT = 11;

  localparam int CYCLE400 = 146097;
  localparam int CYCLE100 = 36524;
  localparam int CYCLE4   = 1461;
  localparam int YEAR_LEN = 365;

  // day before the epoch of the proleptic calendar (0001-01-01 is day 1721426)
  localparam logic signed [26:0] EPOCH_M1 = 27'sd1721425;

  // 0000-03-01 sits at day 1721120; bias by 127 eras so the dividend stays positive
  localparam int            ERA_BIAS = 127;
  localparam logic [25:0]   J2D_OFS  = 26'd16833199;

  // bias of 328 * 25 keeps the quarter year count positive
  localparam int            Q25_BIAS = 328;

  // floor((367 * m - 362) / 12) for every 4 bit month code
  function automatic logic signed [9:0] month_base(input logic [3:0] m);
    logic signed [9:0] v;
    v = '0;
    unique case (m)
      4'd0:  v = -10'sd31;
      4'd1:  v = 10'sd0;
      4'd2:  v = 10'sd31;
      4'd3:  v = 10'sd61;
      4'd4:  v = 10'sd92;
      4'd5:  v = 10'sd122;
      4'd6:  v = 10'sd153;
      4'd7:  v = 10'sd183;
      4'd8:  v = 10'sd214;
      4'd9:  v = 10'sd245;
      4'd10: v = 10'sd275;
      4'd11: v = 10'sd306;
      4'd12: v = 10'sd336;
      4'd13: v = 10'sd367;
      4'd14: v = 10'sd398;
      4'd15: v = 10'sd428;
    endcase
    return v;
  endfunction

  // first day of March-based month k within its year
  function automatic logic [8:0] mp_start(input logic [3:0] k);
    logic [8:0] v;
    v = '0;
    unique case (k)
      4'd0:  v = 9'd0;
      4'd1:  v = 9'd31;
      4'd2:  v = 9'd61;
      4'd3:  v = 9'd92;
      4'd4:  v = 9'd122;
      4'd5:  v = 9'd153;
      4'd6:  v = 9'd184;
      4'd7:  v = 9'd214;
      4'd8:  v = 9'd245;
      4'd9:  v = 9'd275;
      4'd10: v = 9'd306;
      4'd11: v = 9'd337;
      default: v = 9'd0;
    endcase
    return v;
  endfunction

endpackage

/* hdl/gdnc_cdiv.sv */
// Two stage unsigned divide by a constant: reciprocal multiply, then one correction
module gdnc_cdiv #(
  parameter int W = 16,
  parameter int D = 3
) (
  input  logic         clk,
  input  logic [W-1:0] x,
  output logic [W-1:0] q,
  output logic [W-1:0] rem
);

  localparam longint unsigned RECIP_L = (64'd1 << W) / D;
  localparam logic [W:0]      RECIP   = (W+1)'(RECIP_L);
  localparam logic [W-1:0]    DV      = W'(D);

  logic [2*W:0]   prod;
  logic [W-1:0]   q0_r;
  logic [W-1:0]   x_r;
  logic [2*W-1:0] qd;
  logic [W-1:0]   r0;
  logic           fix;
  logic [W-1:0]   q_r;
  logic [W-1:0]   rem_r;

  // estimate is low by at most one
  assign prod = {{(W+1){1'b0}}, x} * {{W{1'b0}}, RECIP};

  always_ff @(posedge clk) begin
    q0_r <= prod[2*W-1:W];
    x_r  <= x;
  end

  assign qd  = {{W{1'b0}}, q0_r} * {{W{1'b0}}, DV};
  assign r0  = x_r - qd[W-1:0];
  assign fix = (r0 >= DV);

  always_ff @(posedge clk) begin
    q_r   <= fix ? q0_r + W'(1) : q0_r;
    rem_r <= fix ? r0 - DV : r0;
  end

  assign q   = q_r;
  assign rem = rem_r;

endmodule

/* hdl/gdnc_d2j.sv */
// Date to day number datapath, four stages
module gdnc_d2j (
  input  logic               clk,
  input  logic signed [15:0] year,
  input  logic [3:0]         month,
  input  logic [4:0]         day_of_month,
  output logic signed [24:0] day_number
);

  logic signed [16:0] p;
  logic signed [14:0] v;
  logic signed [16:0] p1_r;
  logic [14:0]        u1_r;
  logic [3:0]         m1_r;
  logic [4:0]         d1_r;

  logic signed [26:0] s2_r, s3_r;
  logic signed [10:0] md2_r, md3_r;
  logic               mle2_r, mle3_r;
  logic [1:0]         plo2_r, plo3_r;

  logic [14:0]        q25;
  logic [14:0]        r25;
  logic signed [10:0] h;
  logic               y4, y100, y400, leap;
  logic signed [26:0] adj;
  logic signed [26:0] jdn;
  logic signed [24:0] jdn_r;

  assign p = {year[15], year} - 17'sd1;
  assign v = p[16:2];

  always_ff @(posedge clk) begin
    p1_r <= p;
    u1_r <= 15'(v) + 15'(gdnc_pkg::Q25_BIAS * 25);
    m1_r <= month;
    d1_r <= day_of_month;
  end

  // floor(p / 100) = floor(floor(p / 4) / 25)
  gdnc_cdiv #(.W(15), .D(25)) u_div25 (
    .clk (clk),
    .x   (u1_r),
    .q   (q25),
    .rem (r25)
  );

  always_ff @(posedge clk) begin
    s2_r   <= 27'(p1_r) * 27'sd365 + 27'($signed(p1_r[16:2])) + gdnc_pkg::EPOCH_M1;
    md2_r  <= 11'(gdnc_pkg::month_base(m1_r)) + $signed({6'd0, d1_r});
    mle2_r <= (m1_r <= 4'd2);
    plo2_r <= p1_r[1:0];
    s3_r   <= s2_r;
    md3_r  <= md2_r;
    mle3_r <= mle2_r;
    plo3_r <= plo2_r;
  end

  assign h    = $signed({1'b0, q25[9:0]}) - 11'sd328;
  assign y4   = (plo3_r == 2'b11);
  assign y100 = y4 && (r25 == 15'd24);
  assign y400 = y100 && (q25[1:0] == 2'b11);
  assign leap = y4 && (!y100 || y400);

  always_comb begin
    if (mle3_r) begin
      adj = 27'sd0;
    end else if (leap) begin
      adj = -27'sd1;
    end else begin
      adj = -27'sd2;
    end
  end

  assign jdn = s3_r - 27'(h) + 27'($signed(h[10:2])) + 27'(md3_r) + adj;

  always_ff @(posedge clk) begin
    jdn_r <= jdn[24:0];
  end

  assign day_number = jdn_r;

endmodule

/* hdl/gdnc_j2d.sv */
// Day number to date datapath, eleven stages
module gdnc_j2d (
  input  logic               clk,
  input  logic signed [24:0] day_number,
  output logic signed [16:0] year,
  output logic [3:0]         month,
  output logic [4:0]         day
);

  logic [25:0]        u1_r;
  logic [25:0]        q400, r400;
  logic [17:0]        doe;
  logic signed [8:0]  era;
  logic [2:0]         b;
  logic               c;

  logic [17:0]        q1460;
  logic [17:0]        doe4_r, doe5_r;
  logic [2:0]         b4_r, b5_r;
  logic               c4_r, c5_r;
  logic signed [8:0]  era4_r, era5_r, era6_r, era7_r, era8_r, era9_r;

  logic [17:0]        a6_r;
  logic [6:0]         diff6_r, diff7_r, diff8_r;
  logic [17:0]        q365, r365;

  logic [8:0]         yoe;
  logic [1:0]         c100;
  logic [9:0]         doy_w;
  logic [8:0]         doy9_r, yoe9_r;

  logic [3:0]         mp;
  logic signed [16:0] ybase;
  logic [3:0]         mp10_r;
  logic [8:0]         doy10_r;
  logic signed [16:0] ybase10_r;

  logic [8:0]         dom;
  logic signed [16:0] year_r;
  logic [3:0]         month_r;
  logic [4:0]         day_r;

  always_ff @(posedge clk) begin
    u1_r <= {day_number[24], day_number} + gdnc_pkg::J2D_OFS;
  end

  gdnc_cdiv #(.W(26), .D(gdnc_pkg::CYCLE400)) u_div400 (
    .clk (clk),
    .x   (u1_r),
    .q   (q400),
    .rem (r400)
  );

  assign doe = r400[17:0];
  assign era = $signed({1'b0, q400[7:0]}) - 9'(gdnc_pkg::ERA_BIAS);
  assign b   = 3'(doe >= 18'(gdnc_pkg::CYCLE100))
             + 3'(doe >= 18'(2 * gdnc_pkg::CYCLE100))
             + 3'(doe >= 18'(3 * gdnc_pkg::CYCLE100))
             + 3'(doe >= 18'(4 * gdnc_pkg::CYCLE100));
  assign c   = (doe == 18'(gdnc_pkg::CYCLE400 - 1));

  gdnc_cdiv #(.W(18), .D(gdnc_pkg::CYCLE4 - 1)) u_div1460 (
    .clk (clk),
    .x   (doe),
    .q   (q1460),
    .rem ()
  );

  always_ff @(posedge clk) begin
    doe4_r <= doe;
    doe5_r <= doe4_r;
    b4_r   <= b;
    b5_r   <= b4_r;
    c4_r   <= c;
    c5_r   <= c4_r;
    era4_r <= era;
    era5_r <= era4_r;
    era6_r <= era5_r;
    era7_r <= era6_r;
    era8_r <= era7_r;
  end

  // leap days skipped inside the era; year of era follows from a / 365
  always_ff @(posedge clk) begin
    a6_r    <= doe5_r - q1460 + 18'(b5_r) - 18'(c5_r);
    diff6_r <= q1460[6:0] - 7'(b5_r) + 7'(c5_r);
    diff7_r <= diff6_r;
    diff8_r <= diff7_r;
  end

  gdnc_cdiv #(.W(18), .D(gdnc_pkg::YEAR_LEN)) u_div365 (
    .clk (clk),
    .x   (a6_r),
    .q   (q365),
    .rem (r365)
  );

  assign yoe   = q365[8:0];
  assign c100  = 2'(yoe >= 9'd100) + 2'(yoe >= 9'd200) + 2'(yoe >= 9'd300);
  assign doy_w = 10'(r365[8:0]) + 10'(diff8_r) - 10'(yoe[8:2]) + 10'(c100);

  always_ff @(posedge clk) begin
    doy9_r <= doy_w[8:0];
    yoe9_r <= yoe;
    era9_r <= era8_r;
  end

  always_comb begin
    mp = '0;
    for (int k = 1; k < 12; k++) begin
      mp = mp + 4'(doy9_r >= gdnc_pkg::mp_start(4'(k)));
    end
  end

  assign ybase = $signed({{8{era9_r[8]}}, era9_r}) * 17'sd400 + $signed({8'd0, yoe9_r});

  always_ff @(posedge clk) begin
    mp10_r    <= mp;
    doy10_r   <= doy9_r;
    ybase10_r <= ybase;
  end

  assign dom = doy10_r - gdnc_pkg::mp_start(mp10_r) + 9'd1;

  // March-based month: January and February belong to the next year
  always_ff @(posedge clk) begin
    day_r <= dom[4:0];
    if (mp10_r < 4'd10) begin
      month_r <= mp10_r + 4'd3;
      year_r  <= ybase10_r;
    end else begin
      month_r <= mp10_r - 4'd9;
      year_r  <= ybase10_r + 17'sd1;
    end
  end

  assign year  = year_r;
  assign month = month_r;
  assign day   = day_r;

endmodule

/* hdl/gregorian_day_number_converter.sv */
// The out_valid strobe follows the accepting edge with the same delay in both directions.
// Throughput: one word per cycle; busy is high only while rst_n is low.
// The date to day path is delayed to match the 11 stage day to date path,
// which includes three chained constant dividers.
// Reset clears the valid pipeline only; words in flight at reset are dropped.
`include "gregorian_day_number_converter_defines.svh"
module gregorian_day_number_converter (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_operation,
  input  logic signed [15:0] in_year,
  input  logic [3:0]         in_month,
  input  logic [4:0]         in_day_of_month,
  input  logic signed [24:0] in_day_number,
  output logic               out_valid,
  output logic signed [24:0] out_day_number,
  output logic signed [16:0] out_year,
  output logic [3:0]         out_month,
  output logic [4:0]         out_day
);

  localparam int LAT = gdnc_pkg::J2D_LAT;
  localparam int PAD = gdnc_pkg::J2D_LAT - gdnc_pkg::D2J_LAT;

  logic               accept;
  logic [LAT-1:0]     vld_r;
  logic [LAT-1:0]     op_r;
  logic signed [24:0] dn;
  logic signed [24:0] dn_dly_r [PAD];
  logic signed [16:0] j_year;
  logic [3:0]         j_month;
  logic [4:0]         j_day;
  logic               op_o;

  assign busy   = ~rst_n;
  assign accept = start & ~busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[LAT-2:0], accept};
    end
  end

  always_ff @(posedge clk) begin
    op_r <= {op_r[LAT-2:0], in_operation};
  end

  gdnc_d2j u_d2j (
    .clk          (clk),
    .year         (in_year),
    .month        (in_month),
    .day_of_month (in_day_of_month),
    .day_number   (dn)
  );

  gdnc_j2d u_j2d (
    .clk        (clk),
    .day_number (in_day_number),
    .year       (j_year),
    .month      (j_month),
    .day        (j_day)
  );

  always_ff @(posedge clk) begin
    dn_dly_r[0] <= dn;
    for (int i = 1; i < PAD; i++) begin
      dn_dly_r[i] <= dn_dly_r[i-1];
    end
  end

  assign op_o           = op_r[LAT-1];
  assign out_valid      = vld_r[LAT-1];
  assign out_day_number = op_o ? 25'sd0 : dn_dly_r[PAD-1];
  assign out_year       = op_o ? j_year : 17'sd0;
  assign out_month      = op_o ? j_month : 4'd0;
  assign out_day        = op_o ? j_day : 5'd0;

  `GDNC_ASSERT_IMP(a_latency, accept, ##11 out_valid, "word lost in pipeline")
  `GDNC_ASSERT_IMP(a_no_ghost, !$past(accept, LAT), !out_valid, "strobe without a word")
  `GDNC_ASSERT_IMP(a_date_range, out_valid && op_o,
    out_month >= 4'd1 && out_month <= 4'd12 && out_day >= 5'd1 && out_day <= 5'd31,
    "date result out of range")

endmodule
